FILE: rtl/mesh_cell_volume_macros.svh
// Assertion macros for the mesh cell volume block.
// Used by the port checker; no other dependencies.
`ifndef MESH_CELL_VOLUME_MACROS_SVH
`define MESH_CELL_VOLUME_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MCV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MCV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mcv_pkg.sv
// Shared types, constants and lookup functions for the mesh cell volume block.
// No dependencies; used by every RTL file of the block except mcv_ram.
package mcv_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int VOLUME_BITS    = 51;
    localparam int STORE_DEPTH    = 6;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH    = 2;

    // Cell type codes
    localparam logic [1:0] SHAPE_TET   = 2'd0;
    localparam logic [1:0] SHAPE_PYR   = 2'd1;
    localparam logic [1:0] SHAPE_WEDGE = 2'd2;
    localparam logic [1:0] SHAPE_RSVD  = 2'd3;

    // Classification of one vertex, front to back
    typedef struct packed {
        logic [STORE_AW-1:0] idx;
        logic                last;
        logic [1:0]          shape;
    } vtx_ctl_t;

    localparam int CTL_W = $bits(vtx_ctl_t);

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_MUL,
        B_ACC,
        B_SUM,
        B_DIV,
        B_OUT
    } back_state_t;

    // Reserved shape code is handled as a tetrahedron
    function automatic logic [1:0] shape_norm(input logic [1:0] shape);
        return (shape == SHAPE_RSVD) ? SHAPE_TET : shape;
    endfunction

    function automatic logic [2:0] verts_needed(input logic [1:0] shape);
        logic [2:0] n;
        case (shape)
            SHAPE_PYR:   n = 3'd5;
            SHAPE_WEDGE: n = 3'd6;
            default:     n = 3'd4;
        endcase
        return n;
    endfunction

    // Index of the last tetrahedron the cell splits into
    function automatic logic [1:0] last_tet(input logic [1:0] shape);
        logic [1:0] n;
        case (shape)
            SHAPE_PYR:   n = 2'd1;
            SHAPE_WEDGE: n = 2'd2;
            default:     n = 2'd0;
        endcase
        return n;
    endfunction

    // Corner k of tetrahedron tet of the split; corner 0 in the low bits
    function automatic logic [STORE_AW-1:0] tet_vertex(input logic [1:0] shape,
                                                       input logic [1:0] tet,
                                                       input logic [1:0] k);
        logic [4*STORE_AW-1:0] row;
        case ({shape, tet})
            {SHAPE_PYR, 2'd0}:   row = {3'd4, 3'd2, 3'd1, 3'd0};
            {SHAPE_PYR, 2'd1}:   row = {3'd4, 3'd3, 3'd2, 3'd0};
            {SHAPE_WEDGE, 2'd0}: row = {3'd4, 3'd2, 3'd1, 3'd0};
            {SHAPE_WEDGE, 2'd1}: row = {3'd5, 3'd4, 3'd2, 3'd0};
            {SHAPE_WEDGE, 2'd2}: row = {3'd5, 3'd4, 3'd3, 3'd0};
            default:             row = {3'd3, 3'd2, 3'd1, 3'd0};
        endcase
        return row[STORE_AW*k +: STORE_AW];
    endfunction

    // One radix-256 digit of a division by six: v = rem*256 + byte, v < 1536.
    // floor(v*683/4096) is exact over that range. Returns {quotient, remainder}.
    function automatic logic [10:0] div6_digit(input logic [10:0] v);
        logic [20:0] p;
        logic [7:0]  q;
        logic [10:0] r;
        p = 21'(v) * 21'd683;
        q = p[19:12];
        r = v - ({3'b000, q} * 11'd6);
        return {q, r[2:0]};
    endfunction

endpackage

FILE: rtl/mesh_cell_volume.sv
// Channel | Handshake          | Payload
// s_      | s_valid / s_ready  | s_shape, s_x_coord, s_y_coord, s_z_coord (one vertex)
// m_      | m_valid / m_ready  | m_volume, m_cell_type (one per finished cell)
//
// The back part takes one vertex per cycle while idle; on a cell's last vertex it
// runs each tetrahedron through the shared multiplier, then divides by six one byte
// at a time over the NDIG (7 at 16-bit coordinates) bytes of the sum, then loads the
// result. A two-entry queue lets the front keep taking vertices while the back
// computes; a result waits in its output register.
// Reset is synchronous and active low; it clears counters, queue and result valid.
// Top level of the mesh cell volume block; uses mcv_pkg, mcv_front, mcv_queue, mcv_back.
module mesh_cell_volume #(
    parameter int COORD_BITS = mcv_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_shape,
    input  logic signed [COORD_BITS-1:0]    s_x_coord,
    input  logic signed [COORD_BITS-1:0]    s_y_coord,
    input  logic signed [COORD_BITS-1:0]    s_z_coord,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mcv_pkg::VOLUME_BITS-1:0] m_volume,
    output logic [1:0]                      m_cell_type
);

    logic                    f_valid, f_ready;
    mcv_pkg::vtx_ctl_t       f_ctl;
    logic [3*COORD_BITS-1:0] f_coords;
    logic                    b_valid, b_ready;
    mcv_pkg::vtx_ctl_t       b_ctl;
    logic [3*COORD_BITS-1:0] b_coords;

    // Vertex intake and classification
    mcv_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_shape   (s_shape),
        .s_x_coord (s_x_coord),
        .s_y_coord (s_y_coord),
        .s_z_coord (s_z_coord),
        .f_valid   (f_valid),
        .f_ready   (f_ready),
        .f_ctl     (f_ctl),
        .f_coords  (f_coords)
    );

    // Decoupling queue
    mcv_queue #(
        .WIDTH (3 * COORD_BITS),
        .DEPTH (mcv_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_ctl    (f_ctl),
        .in_data   (f_coords),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_ctl   (b_ctl),
        .out_data  (b_coords)
    );

    // Volume computation and result register
    mcv_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (b_valid),
        .q_ready     (b_ready),
        .q_ctl       (b_ctl),
        .q_coords    (b_coords),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_volume    (m_volume),
        .m_cell_type (m_cell_type)
    );

endmodule

FILE: rtl/mcv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/mcv_queue.sv
// Short vertex queue between the front and back parts.
// Uses mcv_pkg for the control word layout.
module mcv_queue #(
    parameter int WIDTH = 48,
    parameter int DEPTH = mcv_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  mcv_pkg::vtx_ctl_t   in_ctl,
    input  logic [WIDTH-1:0]    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mcv_pkg::vtx_ctl_t   out_ctl,
    output logic [WIDTH-1:0]    out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mcv_pkg::vtx_ctl_t  ctl_mem  [DEPTH];
    logic [WIDTH-1:0]   data_mem [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic               push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_ctl   = ctl_mem[rd_ptr_reg];
    assign out_data  = data_mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ctl_mem[wr_ptr_reg]  <= in_ctl;
            data_mem[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/mcv_front.sv
// Front part: takes vertex transfers, latches the cell shape and tags each
// vertex with its store slot and a last-of-cell flag. Uses mcv_pkg.
module mcv_front #(
    parameter int COORD_BITS = mcv_pkg::COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_shape,
    input  logic [COORD_BITS-1:0]   s_x_coord,
    input  logic [COORD_BITS-1:0]   s_y_coord,
    input  logic [COORD_BITS-1:0]   s_z_coord,
    output logic                    f_valid,
    input  logic                    f_ready,
    output mcv_pkg::vtx_ctl_t       f_ctl,
    output logic [3*COORD_BITS-1:0] f_coords
);

    logic [mcv_pkg::STORE_AW-1:0] cnt_reg;
    logic [1:0]                   shape_reg;
    logic [1:0]                   shape_eff;
    logic                         last;
    logic                         push;

    // Shape comes from the first vertex of a cell only
    assign shape_eff = (cnt_reg == '0) ? mcv_pkg::shape_norm(s_shape) : shape_reg;
    assign last      = (3'(cnt_reg) + 3'd1) == mcv_pkg::verts_needed(shape_eff);

    assign s_ready   = f_ready;
    assign f_valid   = s_valid;
    assign push      = s_valid && f_ready;

    assign f_ctl.idx   = cnt_reg;
    assign f_ctl.last  = last;
    assign f_ctl.shape = shape_eff;
    assign f_coords    = {s_z_coord, s_y_coord, s_x_coord};

    // Vertex counter and shape latch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            shape_reg <= mcv_pkg::SHAPE_TET;
        end else if (push) begin
            shape_reg <= shape_eff;
            cnt_reg   <= last ? '0 : cnt_reg + 1'b1;
        end
    end

endmodule

FILE: rtl/mcv_back.sv
// Back part: writes vertices to the store and, on a cell's last vertex,
// sums the absolute triple products with one shared multiplier, divides by
// six digit-serially and drives the result register. Uses mcv_pkg, mcv_ram.
module mcv_back #(
    parameter int COORD_BITS = mcv_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  mcv_pkg::vtx_ctl_t             q_ctl,
    input  logic [3*COORD_BITS-1:0]       q_coords,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mcv_pkg::VOLUME_BITS-1:0] m_volume,
    output logic [1:0]                    m_cell_type
);

    localparam int CB    = COORD_BITS;
    localparam int D     = CB + 1;              // coordinate difference
    localparam int XW    = 2 * D + 1;           // cross product component
    localparam int PW    = 3 * D + 1;           // multiplier output
    localparam int TW    = 3 * D + 3;           // triple product
    localparam int NDIG  = (3 * D + 5 + 7) / 8; // bytes of the cell sum
    localparam int SUM_W = NDIG * 8;
    localparam int CW    = $clog2(NDIG);
    localparam int VW    = mcv_pkg::VOLUME_BITS;
    localparam int EW    = (SUM_W > VW) ? SUM_W : VW + 1;
    localparam int AW    = mcv_pkg::STORE_AW;

    mcv_pkg::back_state_t state_reg, state_next;

    logic              pop, ld_out;
    logic [AW-1:0]     rd_addr;
    logic [3*CB-1:0]   rd_data;

    logic [1:0]        shape_reg;
    logic [1:0]        tet_reg;
    logic [2:0]        rd_reg;
    logic [3:0]        step_reg, pstep_reg;
    logic              pvalid_reg;
    logic [CW-1:0]     div_cnt_reg;
    logic [2:0]        rem_reg;

    logic signed [D-1:0]  rd_ext [3];
    logic signed [D-1:0]  diff   [3];
    logic signed [D-1:0]  a_reg  [3];
    logic signed [D-1:0]  u_reg  [3];
    logic signed [D-1:0]  v_reg  [3];
    logic signed [D-1:0]  w_reg  [3];
    logic signed [XW-1:0] x_reg  [3];
    logic signed [TW-1:0] t_reg;
    logic signed [D-1:0]  mul_a;
    logic signed [XW-1:0] mul_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [XW-1:0] prod_x;
    logic signed [TW-1:0] prod_t;
    logic [TW-1:0]        abs_t;
    logic [SUM_W-1:0]     sum_reg;
    logic [10:0]          digit;
    logic [EW-1:0]        q_ext;

    logic                 m_valid_reg;
    logic [VW-1:0]        volume_reg;
    logic [1:0]           type_reg;

    // Vertex store
    mcv_ram #(
        .WIDTH (3 * CB),
        .DEPTH (mcv_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (pop),
        .waddr (q_ctl.idx),
        .wdata (q_coords),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign pop     = q_valid && q_ready;
    assign rd_addr = mcv_pkg::tet_vertex(shape_reg, tet_reg, rd_reg[1:0]);

    // Read data widened, and its offset from corner a
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rd_ext[k] = $signed({rd_data[k*CB + CB - 1], rd_data[k*CB +: CB]});
            diff[k]   = rd_ext[k] - a_reg[k];
        end
    end

    // Multiplier operand schedule: six cross-product terms, then the dot product
    always_comb begin
        case (step_reg)
            4'd0:    begin mul_a = v_reg[1]; mul_b = XW'(w_reg[2]); end
            4'd1:    begin mul_a = v_reg[2]; mul_b = XW'(w_reg[1]); end
            4'd2:    begin mul_a = v_reg[2]; mul_b = XW'(w_reg[0]); end
            4'd3:    begin mul_a = v_reg[0]; mul_b = XW'(w_reg[2]); end
            4'd4:    begin mul_a = v_reg[0]; mul_b = XW'(w_reg[1]); end
            4'd5:    begin mul_a = v_reg[1]; mul_b = XW'(w_reg[0]); end
            4'd6:    begin mul_a = u_reg[0]; mul_b = x_reg[0]; end
            4'd7:    begin mul_a = u_reg[1]; mul_b = x_reg[1]; end
            default: begin mul_a = u_reg[2]; mul_b = x_reg[2]; end
        endcase
    end

    assign prod_x = $signed(prod_reg[XW-1:0]);
    assign prod_t = TW'(prod_reg);
    assign abs_t  = t_reg[TW-1] ? TW'(-t_reg) : TW'(t_reg);
    assign digit  = mcv_pkg::div6_digit({rem_reg, sum_reg[SUM_W-1 -: 8]});
    assign q_ext  = EW'(sum_reg);

    // Next state and handshake
    always_comb begin
        state_next = state_reg;
        q_ready    = 1'b0;
        ld_out     = 1'b0;
        case (state_reg)
            mcv_pkg::B_IDLE: begin
                q_ready = 1'b1;
                if (q_valid && q_ctl.last) begin
                    state_next = mcv_pkg::B_READ;
                end
            end
            mcv_pkg::B_READ: begin
                if (rd_reg == 3'd4) begin
                    state_next = mcv_pkg::B_MUL;
                end
            end
            mcv_pkg::B_MUL: begin
                if (step_reg == 4'd8) begin
                    state_next = mcv_pkg::B_ACC;
                end
            end
            mcv_pkg::B_ACC: begin
                state_next = mcv_pkg::B_SUM;
            end
            mcv_pkg::B_SUM: begin
                if (tet_reg == mcv_pkg::last_tet(shape_reg)) begin
                    state_next = mcv_pkg::B_DIV;
                end else begin
                    state_next = mcv_pkg::B_READ;
                end
            end
            mcv_pkg::B_DIV: begin
                if (div_cnt_reg == CW'(NDIG - 1)) begin
                    state_next = mcv_pkg::B_OUT;
                end
            end
            mcv_pkg::B_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    ld_out     = 1'b1;
                    state_next = mcv_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = mcv_pkg::B_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mcv_pkg::B_IDLE;
            pvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pvalid_reg <= (state_reg == mcv_pkg::B_MUL);
            if (ld_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Sequencer counters, vertex offsets, sum and divider
    always_ff @(posedge aclk) begin
        case (state_reg)
            mcv_pkg::B_IDLE: begin
                if (pop && q_ctl.last) begin
                    shape_reg <= q_ctl.shape;
                    tet_reg   <= 2'd0;
                    rd_reg    <= 3'd0;
                    sum_reg   <= '0;
                end
            end
            mcv_pkg::B_READ: begin
                rd_reg <= rd_reg + 3'd1;
                for (int k = 0; k < 3; k++) begin
                    case (rd_reg)
                        3'd1:    a_reg[k] <= rd_ext[k];
                        3'd2:    u_reg[k] <= diff[k];
                        3'd3:    v_reg[k] <= diff[k];
                        3'd4:    w_reg[k] <= diff[k];
                        default: ;
                    endcase
                end
                step_reg <= 4'd0;
            end
            mcv_pkg::B_MUL: begin
                step_reg <= step_reg + 4'd1;
            end
            mcv_pkg::B_SUM: begin
                sum_reg     <= sum_reg + SUM_W'(abs_t);
                tet_reg     <= tet_reg + 2'd1;
                rd_reg      <= 3'd0;
                div_cnt_reg <= '0;
                rem_reg     <= 3'd0;
            end
            mcv_pkg::B_DIV: begin
                // Quotient bytes shift in as dividend bytes shift out
                sum_reg     <= {sum_reg[SUM_W-9:0], digit[10:3]};
                rem_reg     <= digit[2:0];
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Multiplier with registered product, accumulated in the following cycle
    always_ff @(posedge aclk) begin
        prod_reg  <= mul_a * mul_b;
        pstep_reg <= step_reg;
        if (pvalid_reg) begin
            case (pstep_reg)
                4'd0:    x_reg[0] <= prod_x;
                4'd1:    x_reg[0] <= x_reg[0] - prod_x;
                4'd2:    x_reg[1] <= prod_x;
                4'd3:    x_reg[1] <= x_reg[1] - prod_x;
                4'd4:    x_reg[2] <= prod_x;
                4'd5:    x_reg[2] <= x_reg[2] - prod_x;
                4'd6:    t_reg    <= prod_t;
                default: t_reg    <= t_reg + prod_t;
            endcase
        end
    end

    // Result register, saturated to the volume width
    always_ff @(posedge aclk) begin
        if (ld_out) begin
            volume_reg <= (q_ext > EW'({VW{1'b1}})) ? {VW{1'b1}} : q_ext[VW-1:0];
            type_reg   <= shape_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_volume    = volume_reg;
    assign m_cell_type = type_reg;

endmodule

FILE: rtl/mcv_checker.sv
// Port-level checker for mesh_cell_volume, attached by bind.
// Uses mcv_pkg and the assertion macros header.
`include "mesh_cell_volume_macros.svh"

module mcv_checker #(
    parameter int COORD_BITS = mcv_pkg::COORD_BITS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [1:0]                      s_shape,
    input logic [COORD_BITS-1:0]           s_x_coord,
    input logic [COORD_BITS-1:0]           s_y_coord,
    input logic [COORD_BITS-1:0]           s_z_coord,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [mcv_pkg::VOLUME_BITS-1:0] m_volume,
    input logic [1:0]                      m_cell_type
);

    logic [2:0] cnt_reg;
    logic [1:0] shape_reg;
    logic [1:0] shape_eff;
    logic [3:0] pend_reg;
    logic       s_xfer, m_xfer, cell_done;
    logic       s_stall;

    assign shape_eff  = (cnt_reg == 3'd0) ? mcv_pkg::shape_norm(s_shape) : shape_reg;
    assign s_xfer     = s_valid && s_ready;
    assign m_xfer     = m_valid && m_ready;
    assign cell_done  = s_xfer && ((cnt_reg + 3'd1) == mcv_pkg::verts_needed(shape_eff));
    assign s_stall    = s_valid && !s_ready;

    // Cells completed on the input side but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 3'd0;
            shape_reg <= mcv_pkg::SHAPE_TET;
            pend_reg  <= 4'd0;
        end else begin
            if (s_xfer) begin
                shape_reg <= shape_eff;
                cnt_reg   <= cell_done ? 3'd0 : cnt_reg + 3'd1;
            end
            if (cell_done && !m_xfer) begin
                pend_reg <= pend_reg + 4'd1;
            end else if (m_xfer && !cell_done) begin
                pend_reg <= pend_reg - 4'd1;
            end
        end
    end

    `MCV_ASSERT_NXT(a_input_hold, aclk, aresetn, s_stall, s_valid && $stable(s_shape) && $stable(s_x_coord) && $stable(s_y_coord) && $stable(s_z_coord), "vertex changed while stalled")
    `MCV_ASSERT_NXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_volume) && $stable(m_cell_type), "result changed while stalled")
    `MCV_ASSERT_IMP(a_result_has_cell, aclk, aresetn, m_valid, pend_reg != 4'd0, "result without a completed cell")
    `MCV_ASSERT_IMP(a_result_type, aclk, aresetn, m_valid, m_cell_type != mcv_pkg::SHAPE_RSVD, "reserved cell type on result")

endmodule

bind mesh_cell_volume mcv_checker #(
    .COORD_BITS (COORD_BITS)
) u_mcv_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_shape     (s_shape),
    .s_x_coord   (s_x_coord),
    .s_y_coord   (s_y_coord),
    .s_z_coord   (s_z_coord),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_volume    (m_volume),
    .m_cell_type (m_cell_type)
);

FILE: dv/tb_mesh_cell_volume.sv
// Self-checking testbench for mesh_cell_volume: streams cell vertices, predicts each
// cell volume in the bench and compares every result transfer in order.
// Depends on mcv_pkg and the mesh_cell_volume RTL only.
`timescale 1ns / 100ps

module tb_mesh_cell_volume;

    localparam int CB          = mcv_pkg::COORD_BITS_DEF;
    localparam int VB          = mcv_pkg::VOLUME_BITS;
    localparam int SETTLE_CYC  = 100;
    localparam int COORD_FULL  = 0;
    localparam int COORD_SMALL = 1;
    localparam int COORD_EDGE  = 2;

    typedef struct {
        logic [VB-1:0] volume;
        logic [1:0]    cell_type;
    } cell_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [1:0]             s_shape;
    logic signed [CB-1:0]   s_x_coord;
    logic signed [CB-1:0]   s_y_coord;
    logic signed [CB-1:0]   s_z_coord;
    logic                   m_valid;
    logic                   m_ready;
    logic [VB-1:0]          m_volume;
    logic [1:0]             m_cell_type;

    // Bench copy of the cell being assembled
    longint      vtx_pos [0:5][0:2];
    int unsigned held_verts;
    logic [1:0]  cell_shape;
    cell_result_t volume_due [$];

    bit          no_idle;
    int unsigned errors;
    int unsigned verts_sent;
    int unsigned cells_done;
    int unsigned cells_by_type [0:2];

    mesh_cell_volume #(.COORD_BITS(CB)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_shape    (s_shape),
        .s_x_coord  (s_x_coord),
        .s_y_coord  (s_y_coord),
        .s_z_coord  (s_z_coord),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_volume   (m_volume),
        .m_cell_type(m_cell_type)
    );

    // 8 ns clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Absolute scalar triple product of one tetrahedron of the held cell
    function automatic longint unsigned tet_triple_abs(int a, int b, int c, int d);
        longint u [0:2];
        longint v [0:2];
        longint w [0:2];
        longint t;
        for (int k = 0; k < 3; k++) begin
            u[k] = vtx_pos[b][k] - vtx_pos[a][k];
            v[k] = vtx_pos[c][k] - vtx_pos[a][k];
            w[k] = vtx_pos[d][k] - vtx_pos[a][k];
        end
        t = u[0] * (v[1] * w[2] - v[2] * w[1])
          + u[1] * (v[2] * w[0] - v[0] * w[2])
          + u[2] * (v[0] * w[1] - v[1] * w[0]);
        return (t < 0) ? longint'(-t) : longint'(t);
    endfunction

    // Track one accepted vertex; queue the volume when the cell is complete
    task automatic track_vertex(input logic [1:0] shp, input logic signed [CB-1:0] x,
                                input logic signed [CB-1:0] y,
                                input logic signed [CB-1:0] z);
        int unsigned  needed;
        logic [65:0]  sum;
        logic [65:0]  quot;
        cell_result_t res;
        if (held_verts == 0)
            cell_shape = (shp == mcv_pkg::SHAPE_RSVD) ? mcv_pkg::SHAPE_TET : shp;
        vtx_pos[held_verts][0] = x;
        vtx_pos[held_verts][1] = y;
        vtx_pos[held_verts][2] = z;
        held_verts++;
        case (cell_shape)
            mcv_pkg::SHAPE_PYR:   needed = 5;
            mcv_pkg::SHAPE_WEDGE: needed = 6;
            default:              needed = 4;
        endcase
        if (held_verts < needed)
            return;
        case (cell_shape)
            mcv_pkg::SHAPE_PYR: sum = 66'(tet_triple_abs(0, 1, 2, 4))
                                    + 66'(tet_triple_abs(0, 2, 3, 4));
            mcv_pkg::SHAPE_WEDGE: sum = 66'(tet_triple_abs(0, 1, 2, 4))
                                      + 66'(tet_triple_abs(0, 2, 4, 5))
                                      + 66'(tet_triple_abs(0, 3, 4, 5));
            default: sum = 66'(tet_triple_abs(0, 1, 2, 3));
        endcase
        // saturate the sum at 64 bits, the quotient at the output width
        if (sum > 66'({64{1'b1}}))
            sum = 66'({64{1'b1}});
        quot = sum / 6;
        if (quot > 66'({VB{1'b1}}))
            quot = 66'({VB{1'b1}});
        res.volume    = quot[VB-1:0];
        res.cell_type = cell_shape;
        volume_due.push_back(res);
        cells_by_type[cell_shape]++;
        held_verts = 0;
    endtask

    // Drive one vertex and hold it until the transfer; returns at a falling edge
    task automatic send_vertex(input logic [1:0] shp, input logic signed [CB-1:0] x,
                               input logic signed [CB-1:0] y,
                               input logic signed [CB-1:0] z);
        if (!no_idle) begin
            while ($urandom_range(99) < 25) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_shape   <= shp;
        s_x_coord <= x;
        s_y_coord <= y;
        s_z_coord <= z;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        track_vertex(shp, x, y, z);
        verts_sent++;
        @(negedge aclk);
    endtask

    // Stop sending and let every pending cell come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (volume_due.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [CB-1:0] rand_coord(int mode);
        int v;
        case (mode)
            COORD_FULL:  v = int'($urandom);
            COORD_SMALL: v = int'($urandom_range(1024)) - 512;
            COORD_EDGE: begin
                case ($urandom_range(4))
                    0:       v = -32768;
                    1:       v = -32767;
                    2:       v = 32766;
                    3:       v = 32767;
                    default: v = 0;
                endcase
            end
            default: v = 0;
        endcase
        return v[CB-1:0];
    endfunction

    // One cell with random content; shape bits on later vertices are noise
    task automatic send_random_cell();
        logic [1:0]           shp;
        int                   nverts;
        int                   mode;
        bit                   flat;
        logic signed [CB-1:0] flat_z;
        logic signed [CB-1:0] zc;
        shp    = ($urandom_range(9) == 0) ? mcv_pkg::SHAPE_RSVD : 2'($urandom_range(2));
        nverts = (shp == mcv_pkg::SHAPE_PYR) ? 5 : (shp == mcv_pkg::SHAPE_WEDGE) ? 6 : 4;
        mode   = $urandom_range(2);
        flat   = ($urandom_range(9) == 0);
        flat_z = rand_coord(mode);
        for (int i = 0; i < nverts; i++) begin
            zc = flat ? flat_z : rand_coord(mode);
            send_vertex((i == 0) ? shp : 2'($urandom_range(3)),
                        rand_coord(mode), rand_coord(mode), zc);
        end
    endtask

    // Axis-aligned tetrahedron of edge 256, then one with every coordinate at a range limit
    task automatic test_tetrahedra();
        send_vertex(mcv_pkg::SHAPE_TET, 16'sd0,   16'sd0,   16'sd0);
        send_vertex(mcv_pkg::SHAPE_TET, 16'sd256, 16'sd0,   16'sd0);
        send_vertex(mcv_pkg::SHAPE_TET, 16'sd0,   16'sd256, 16'sd0);
        send_vertex(mcv_pkg::SHAPE_TET, 16'sd0,   16'sd0,   16'sd256);
        send_vertex(mcv_pkg::SHAPE_TET, -16'sd32768, -16'sd32768, -16'sd32768);
        send_vertex(mcv_pkg::SHAPE_TET, 16'sd32767,  -16'sd32768, -16'sd32768);
        send_vertex(mcv_pkg::SHAPE_TET, -16'sd32768, 16'sd32767,  -16'sd32768);
        send_vertex(mcv_pkg::SHAPE_TET, -16'sd32768, -16'sd32768, 16'sd32767);
        wait_drained();
    endtask

    // Square pyramid, apex last
    task automatic test_pyramid();
        send_vertex(mcv_pkg::SHAPE_PYR, 16'sd0,   16'sd0,   16'sd0);
        send_vertex(mcv_pkg::SHAPE_PYR, 16'sd512, 16'sd0,   16'sd0);
        send_vertex(mcv_pkg::SHAPE_PYR, 16'sd512, 16'sd512, 16'sd0);
        send_vertex(mcv_pkg::SHAPE_PYR, 16'sd0,   16'sd512, 16'sd0);
        send_vertex(mcv_pkg::SHAPE_PYR, 16'sd256, 16'sd256, 16'sd768);
        wait_drained();
    endtask

    // Triangular prism with negative coordinates
    task automatic test_wedge();
        send_vertex(mcv_pkg::SHAPE_WEDGE, -16'sd256, -16'sd256, -16'sd256);
        send_vertex(mcv_pkg::SHAPE_WEDGE, 16'sd0,    -16'sd256, -16'sd256);
        send_vertex(mcv_pkg::SHAPE_WEDGE, -16'sd256, 16'sd0,    -16'sd256);
        send_vertex(mcv_pkg::SHAPE_WEDGE, -16'sd256, -16'sd256, 16'sd300);
        send_vertex(mcv_pkg::SHAPE_WEDGE, 16'sd0,    -16'sd256, 16'sd300);
        send_vertex(mcv_pkg::SHAPE_WEDGE, -16'sd256, 16'sd0,    16'sd300);
        wait_drained();
    endtask

    // Reserved code counts as a tetrahedron; later shape bits ignored; flat cell is zero
    task automatic test_reserved_flat();
        send_vertex(mcv_pkg::SHAPE_RSVD,  16'sd100,  16'sd100, 16'sd77);
        send_vertex(mcv_pkg::SHAPE_WEDGE, 16'sd900,  16'sd40,  16'sd77);
        send_vertex(mcv_pkg::SHAPE_PYR,   -16'sd300, 16'sd700, 16'sd77);
        send_vertex(mcv_pkg::SHAPE_WEDGE, 16'sd5,    -16'sd9,  16'sd77);
        wait_drained();
    endtask

    // Random cells with idling on both sides
    task automatic test_random_cells(input int unsigned n_verts);
        int unsigned stop_at;
        stop_at = verts_sent + n_verts;
        while (verts_sent < stop_at)
            send_random_cell();
        wait_drained();
    endtask

    // Same traffic with both sides always ready
    task automatic test_back_to_back(input int unsigned n_verts);
        int unsigned stop_at;
        stop_at = verts_sent + n_verts;
        no_idle = 1'b1;
        while (verts_sent < stop_at)
            send_random_cell();
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Result side back-pressure
    always @(negedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 25);
    end

    // Compare every result transfer with the oldest predicted volume
    always @(posedge aclk) begin : check_cells
        cell_result_t want;
        if (aresetn && m_valid && m_ready) begin
            cells_done++;
            if (volume_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result volume=%0d cell_type=%0d",
                         $time, m_volume, m_cell_type);
            end else begin
                want = volume_due.pop_front();
                if (m_volume !== want.volume) begin
                    errors++;
                    $display("%0t: volume expected %0d actual %0d",
                             $time, want.volume, m_volume);
                end
                if (m_cell_type !== want.cell_type) begin
                    errors++;
                    $display("%0t: cell_type expected %0d actual %0d",
                             $time, want.cell_type, m_cell_type);
                end
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_shape    = '0;
        s_x_coord  = '0;
        s_y_coord  = '0;
        s_z_coord  = '0;
        m_ready    = 1'b0;
        no_idle    = 1'b0;
        held_verts = 0;
        cell_shape = mcv_pkg::SHAPE_TET;
        errors     = 0;
        verts_sent = 0;
        cells_done = 0;
        foreach (cells_by_type[i])
            cells_by_type[i] = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_tetrahedra();
        test_pyramid();
        test_wedge();
        test_reserved_flat();
        test_random_cells(600);
        test_back_to_back(250);
        test_random_cells(250);

        // let anything stray come out before judging
        repeat (SETTLE_CYC) @(posedge aclk);
        if (volume_due.size() != 0) begin
            errors++;
            $display("%0t: %0d predicted volumes never arrived", $time, volume_due.size());
        end
        $display("Sent %0d vertices; %0d results checked (tet %0d, pyramid %0d, wedge %0d).",
                 verts_sent, cells_done, cells_by_type[mcv_pkg::SHAPE_TET],
                 cells_by_type[mcv_pkg::SHAPE_PYR], cells_by_type[mcv_pkg::SHAPE_WEDGE]);
        if (errors == 0) begin
            $display("mesh_cell_volume verification clean");
        end else begin
            $display("%0d errors", errors);
            $display("mesh_cell_volume verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("%0t: timeout", $time);
        $display("mesh_cell_volume verification failed");
        $finish;
    end

endmodule

FILE: mesh_cell_volume.f
+incdir+rtl
rtl/mcv_pkg.sv
rtl/mcv_ram.sv
rtl/mcv_queue.sv
rtl/mcv_front.sv
rtl/mcv_back.sv
rtl/mesh_cell_volume.sv
rtl/mcv_checker.sv
dv/tb_mesh_cell_volume.sv
